// ===== hdl/sart_pkg.sv =====
// shared types and constants for the sorted address region table
// no dependencies; used by sart_cell and sorted_address_region_table

package sart_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int ADDR_BITS_DEF = 32;

    localparam int KIND_W  = 2;
    localparam int START_W = 32;
    localparam int SIZE_W  = 32;
    localparam int IDX_W   = 6;
    localparam int STAT_W  = 3;
    localparam int RIDX_W  = 6;
    localparam int CNT_W   = 7;
    localparam int CAP_W   = 7;

    // input tdata layout, lowest bit up
    localparam int IN_KIND_LSB  = 0;
    localparam int IN_START_LSB = IN_KIND_LSB + KIND_W;
    localparam int IN_SIZE_LSB  = IN_START_LSB + START_W;
    localparam int IN_IDX_LSB   = IN_SIZE_LSB + SIZE_W;
    localparam int IN_BITS      = IN_IDX_LSB + IDX_W;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

    // output tdata layout, lowest bit up
    localparam int OUT_STAT_LSB = 0;
    localparam int OUT_RIDX_LSB = OUT_STAT_LSB + STAT_W;
    localparam int OUT_CNT_LSB  = OUT_RIDX_LSB + RIDX_W;
    localparam int OUT_BITS     = OUT_CNT_LSB + CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef enum logic [KIND_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_FIND   = 2'd2,
        REQ_REMOVE = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_NULL      = 3'd4
    } t_status;

    typedef struct packed {
        logic cmp;
        logic vld;
        logic take_new;
        logic take_left;
        logic take_right;
    } t_cell_ctl;

endpackage

// ===== hdl/sart_cell.sv =====
// one table entry: start and size storage, key compare flags, neighbour shift
// depends on sart_pkg

module sart_cell #(
    parameter int ADDR_BITS = sart_pkg::ADDR_BITS_DEF
) (
    input  logic                        i_clk,
    input  sart_pkg::t_cell_ctl         i_ctl,
    input  logic [ADDR_BITS-1:0]        i_cmp_key,
    input  logic [ADDR_BITS-1:0]        i_new_start,
    input  logic [sart_pkg::SIZE_W-1:0] i_new_size,
    input  logic [ADDR_BITS-1:0]        i_left_start,
    input  logic [sart_pkg::SIZE_W-1:0] i_left_size,
    input  logic [ADDR_BITS-1:0]        i_right_start,
    input  logic [sart_pkg::SIZE_W-1:0] i_right_size,
    output logic [ADDR_BITS-1:0]        o_start,
    output logic [sart_pkg::SIZE_W-1:0] o_size,
    output logic                        o_ge,
    output logic                        o_eq
);

    logic [ADDR_BITS-1:0]        r_start;
    logic [sart_pkg::SIZE_W-1:0] r_size;
    logic                        r_ge;
    logic                        r_eq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.take_new) begin
            r_start <= i_new_start;
            r_size  <= i_new_size;
        end else if (i_ctl.take_left) begin
            r_start <= i_left_start;
            r_size  <= i_left_size;
        end else if (i_ctl.take_right) begin
            r_start <= i_right_start;
            r_size  <= i_right_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_ge <= i_ctl.vld && (r_start >= i_cmp_key);
            r_eq <= (r_start == i_cmp_key);
        end
    end

    assign o_start = r_start;
    assign o_size  = r_size;
    assign o_ge    = r_ge;
    assign o_eq    = r_eq;

endmodule

// ===== hdl/sorted_address_region_table.sv =====
// top level of the sorted address region table: request handshake, control and cell row
// depends on sart_pkg and sart_cell

// Holds up to DEPTH regions (start address, size) in a row of cells, sorted by start
// address when placed by insert; append puts an entry at the end. In the cycle a
// transaction is accepted every cell compares its start against the key. In the
// EXEC state, once the output register is free or being read, the first matching
// cell is located, the cells from the insert or remove point shift by one place in
// parallel and the result is written to the output register. The block takes a new
// transaction only in IDLE, after that write; a stalled result holds EXEC.
// Entries are never cleared, so no initialisation pass follows reset.

module sorted_address_region_table #(
    parameter int DEPTH     = sart_pkg::DEPTH_DEF,
    parameter int ADDR_BITS = sart_pkg::ADDR_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // fields: req_type, entry_start, entry_size, entry_index
    input  logic [sart_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // fields: status, result_index, entry_count
    output logic [sart_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             i_cfg_wr_en,
    input  logic [sart_pkg::CAP_W-1:0]       i_cfg_wr_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > sart_pkg::CAP_W) ? CW : sart_pkg::CAP_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                          r_state;
    logic [CW-1:0]                   r_count;
    logic [sart_pkg::CAP_W-1:0]      r_cap;
    sart_pkg::t_req                  r_kind;
    logic [ADDR_BITS-1:0]            r_key;
    logic [sart_pkg::SIZE_W-1:0]     r_size;
    logic [sart_pkg::IDX_W-1:0]      r_idx;
    logic                            r_out_valid;
    logic [sart_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic                            in_fire;
    logic                            go;
    logic [ADDR_BITS-1:0]            in_key;
    logic [DEPTH-1:0]                ge_vec;
    logic [DEPTH-1:0]                eq_vec;
    logic [DEPTH-1:0]                first;
    logic                            any_ge;
    logic [IW-1:0]                   first_pos;
    logic [IW-1:0]                   ins_pos;
    logic [XW-1:0]                   count_x;
    logic [XW-1:0]                   idx_x;
    logic                            full;
    logic                            do_ins;
    logic                            do_rem;
    sart_pkg::t_status               status;
    logic [IW-1:0]                   res_pos;
    logic [CW-1:0]                   n_count;
    logic [DEPTH-1:0]                take_new_vec;

    logic [ADDR_BITS-1:0]            cell_start [DEPTH];
    logic [sart_pkg::SIZE_W-1:0]     cell_size  [DEPTH];
    sart_pkg::t_cell_ctl             cell_ctl   [DEPTH];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign go            = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);
    assign in_key        = ADDR_BITS'(s_axis_tdata[sart_pkg::IN_START_LSB +: sart_pkg::START_W]);

    // lowest cell at or above the key
    assign first  = ge_vec & (~ge_vec + DEPTH'(1));
    assign any_ge = |ge_vec;

    always_comb begin
        first_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first[i]) begin
                first_pos = first_pos | IW'(i);
            end
        end
    end

    assign count_x = XW'(r_count);
    assign idx_x   = XW'(r_idx);
    assign full    = (count_x >= XW'(r_cap)) || (r_count == CW'(DEPTH));
    assign ins_pos = (r_kind == sart_pkg::REQ_INSERT && any_ge) ? first_pos : IW'(r_count);

    always_comb begin
        status  = sart_pkg::ST_OK;
        res_pos = '0;
        do_ins  = 1'b0;
        do_rem  = 1'b0;
        n_count = r_count;
        unique case (r_kind)
            sart_pkg::REQ_REMOVE: begin
                if (idx_x >= count_x) begin
                    status = sart_pkg::ST_BAD_INDEX;
                end else begin
                    do_rem  = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            sart_pkg::REQ_FIND: begin
                if (r_key == '0) begin
                    status = sart_pkg::ST_NULL;
                end else if (any_ge && |(first & eq_vec)) begin
                    res_pos = first_pos;
                end else begin
                    status = sart_pkg::ST_NOT_FOUND;
                end
            end
            sart_pkg::REQ_APPEND, sart_pkg::REQ_INSERT: begin
                if (r_key == '0) begin
                    status = sart_pkg::ST_NULL;
                end else if (full) begin
                    status = sart_pkg::ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    res_pos = ins_pos;
                    n_count = r_count + CW'(1);
                end
            end
            default: begin
                status = sart_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cap       <= sart_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind <= sart_pkg::t_req'(s_axis_tdata[sart_pkg::IN_KIND_LSB +: sart_pkg::KIND_W]);
            r_key  <= in_key;
            r_size <= s_axis_tdata[sart_pkg::IN_SIZE_LSB +: sart_pkg::SIZE_W];
            r_idx  <= s_axis_tdata[sart_pkg::IN_IDX_LSB +: sart_pkg::IDX_W];
        end
        if (go) begin
            r_out_data <= sart_pkg::OUT_TDATA_W'({
                sart_pkg::CNT_W'(n_count),
                sart_pkg::RIDX_W'(res_pos),
                status
            });
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [ADDR_BITS-1:0]        left_start;
            logic [sart_pkg::SIZE_W-1:0] left_size;
            logic [ADDR_BITS-1:0]        right_start;
            logic [sart_pkg::SIZE_W-1:0] right_size;

            if (g == 0) begin : g_left_edge
                assign left_start = '0;
                assign left_size  = '0;
            end else begin : g_left
                assign left_start = cell_start[g-1];
                assign left_size  = cell_size[g-1];
            end

            if (g == DEPTH - 1) begin : g_right_edge
                assign right_start = '0;
                assign right_size  = '0;
            end else begin : g_right
                assign right_start = cell_start[g+1];
                assign right_size  = cell_size[g+1];
            end

            assign cell_ctl[g].cmp        = in_fire;
            assign cell_ctl[g].vld        = (CW'(g) < r_count);
            assign cell_ctl[g].take_new   = go && do_ins && (IW'(g) == ins_pos);
            assign cell_ctl[g].take_left  = go && do_ins && (IW'(g) > ins_pos)
                                            && (CW'(g) <= r_count);
            assign cell_ctl[g].take_right = go && do_rem && (XW'(g) >= idx_x)
                                            && ((XW'(g) + XW'(1)) < count_x);
            assign take_new_vec[g]        = cell_ctl[g].take_new;

            sart_cell #(
                .ADDR_BITS (ADDR_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctl         (cell_ctl[g]),
                .i_cmp_key     (in_key),
                .i_new_start   (r_key),
                .i_new_size    (r_size),
                .i_left_start  (left_start),
                .i_left_size   (left_size),
                .i_right_start (right_start),
                .i_right_size  (right_size),
                .o_start       (cell_start[g]),
                .o_size        (cell_size[g]),
                .o_ge          (ge_vec[g]),
                .o_eq          (eq_vec[g])
            );
        end
    endgenerate

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above table depth");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !go |=> $stable(r_count))
        else $error("entry count changed without a completed request");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && do_ins |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the table by one");

    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |-> $onehot0(take_new_vec))
        else $error("more than one cell takes the new entry");

endmodule

// ===== tb/sorted_address_region_table_test.sv =====
// testbench for sorted_address_region_table: directed and random request streams, each result
// checked against an in-bench model of the sorted region table
// depends on sart_pkg and the sorted_address_region_table rtl

module sorted_address_region_table_test;

    typedef struct packed {
        sart_pkg::t_status           status;
        logic [sart_pkg::RIDX_W-1:0] ridx;
        logic [sart_pkg::CNT_W-1:0]  count;
    } t_region_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic [sart_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [sart_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [sart_pkg::CAP_W-1:0]       cfg_wr_data = '0;

    // model of the table
    logic [sart_pkg::START_W-1:0] tbl_start [sart_pkg::DEPTH_DEF];
    logic [sart_pkg::SIZE_W-1:0]  tbl_size [sart_pkg::DEPTH_DEF];
    int                           tbl_count = 0;
    logic [sart_pkg::CAP_W-1:0]   tbl_cap = sart_pkg::CAP_RESET;

    t_region_result expected_results [$];
    int             mismatch_count = 0;
    bit             no_gaps = 1'b0;
    int             sink_hold = 0;

    sorted_address_region_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_tdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return int'($urandom_range(1, 3));
        end
        if (r < 98) begin
            return int'($urandom_range(4, 10));
        end
        return int'($urandom_range(20, 60));
    endfunction

    function automatic int lower_slot(logic [sart_pkg::START_W-1:0] key);
        int i;
        for (i = 0; i < tbl_count; i++) begin
            if (tbl_start[i] >= key) begin
                return i;
            end
        end
        return tbl_count;
    endfunction

    function automatic t_region_result table_apply(sart_pkg::t_req kind,
                                                   logic [sart_pkg::START_W-1:0] key,
                                                   logic [sart_pkg::SIZE_W-1:0] len,
                                                   logic [sart_pkg::IDX_W-1:0] idx);
        t_region_result r;
        int pos;
        int limit;
        int i;
        r.status = sart_pkg::ST_OK;
        r.ridx = '0;
        limit = (tbl_cap > sart_pkg::DEPTH_DEF) ? sart_pkg::DEPTH_DEF : int'(tbl_cap);
        if (kind == sart_pkg::REQ_REMOVE) begin
            if (int'(idx) >= tbl_count) begin
                r.status = sart_pkg::ST_BAD_INDEX;
            end else begin
                for (i = int'(idx); i + 1 < tbl_count; i++) begin
                    tbl_start[i] = tbl_start[i + 1];
                    tbl_size[i] = tbl_size[i + 1];
                end
                tbl_count--;
            end
        end else if (key == '0) begin
            r.status = sart_pkg::ST_NULL;
        end else if (kind == sart_pkg::REQ_FIND) begin
            pos = lower_slot(key);
            if (pos < tbl_count && tbl_start[pos] == key) begin
                r.ridx = sart_pkg::RIDX_W'(pos);
            end else begin
                r.status = sart_pkg::ST_NOT_FOUND;
            end
        end else if (tbl_count >= limit) begin
            r.status = sart_pkg::ST_FULL;
        end else begin
            pos = (kind == sart_pkg::REQ_APPEND) ? tbl_count : lower_slot(key);
            for (i = tbl_count; i > pos; i--) begin
                tbl_start[i] = tbl_start[i - 1];
                tbl_size[i] = tbl_size[i - 1];
            end
            tbl_start[pos] = key;
            tbl_size[pos] = len;
            tbl_count++;
            r.ridx = sart_pkg::RIDX_W'(pos);
        end
        r.count = sart_pkg::CNT_W'(tbl_count);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_request(input sart_pkg::t_req kind,
                                input logic [sart_pkg::START_W-1:0] key,
                                input logic [sart_pkg::SIZE_W-1:0] len,
                                input logic [sart_pkg::IDX_W-1:0] idx);
        int gap;
        logic [sart_pkg::IN_TDATA_W-1:0] word;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        word = '0;
        word[sart_pkg::IN_KIND_LSB +: sart_pkg::KIND_W] = kind;
        word[sart_pkg::IN_START_LSB +: sart_pkg::START_W] = key;
        word[sart_pkg::IN_SIZE_LSB +: sart_pkg::SIZE_W] = len;
        word[sart_pkg::IN_IDX_LSB +: sart_pkg::IDX_W] = idx;
        s_tdata <= word;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        expected_results.push_back(table_apply(kind, key, len, idx));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [sart_pkg::CAP_W-1:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        tbl_cap = value;
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [sart_pkg::START_W-1:0] random_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end
        if (r < 15) begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0001;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        if (r < 45) begin
            return $urandom_range(1, 24);
        end
        return $urandom;
    endfunction

    task automatic random_request();
        int unsigned r;
        sart_pkg::t_req kind;
        logic [sart_pkg::START_W-1:0] key;
        logic [sart_pkg::IDX_W-1:0] idx;
        r = $urandom_range(0, 99);
        kind = (r < 10) ? sart_pkg::REQ_APPEND :
               (r < 45) ? sart_pkg::REQ_INSERT :
               (r < 75) ? sart_pkg::REQ_FIND : sart_pkg::REQ_REMOVE;
        key = random_key();
        idx = sart_pkg::IDX_W'($urandom_range(0, 63));
        if (kind == sart_pkg::REQ_FIND && tbl_count > 0 && $urandom_range(0, 99) < 60) begin
            key = tbl_start[$urandom_range(0, tbl_count - 1)];
        end
        if (kind == sart_pkg::REQ_REMOVE && tbl_count > 0 && $urandom_range(0, 99) < 85) begin
            idx = sart_pkg::IDX_W'($urandom_range(0, tbl_count - 1));
        end
        send_request(kind, key, $urandom, idx);
    endtask

    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            m_tready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            m_tready <= 1'b1;
            sink_hold <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_region_result got;
        t_region_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.status = sart_pkg::t_status'(
                m_tdata[sart_pkg::OUT_STAT_LSB +: sart_pkg::STAT_W]);
            got.ridx = m_tdata[sart_pkg::OUT_RIDX_LSB +: sart_pkg::RIDX_W];
            got.count = m_tdata[sart_pkg::OUT_CNT_LSB +: sart_pkg::CNT_W];
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d", got.status));
            end else begin
                want = expected_results.pop_front();
                if (got.status != want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.status, want.status));
                end
                if (got.ridx != want.ridx) begin
                    report_mismatch($sformatf("result_index %0d, expected %0d",
                                              got.ridx, want.ridx));
                end
                if (got.count != want.count) begin
                    report_mismatch($sformatf("entry_count %0d, expected %0d",
                                              got.count, want.count));
                end
            end
        end
    end

    task automatic test_directed();
        send_request(sart_pkg::REQ_FIND, 32'h0000_0100, 32'h0, 6'd0);
        send_request(sart_pkg::REQ_REMOVE, 32'h0, 32'h0, 6'd0);
        send_request(sart_pkg::REQ_APPEND, 32'h0, 32'h55, 6'd0);
        send_request(sart_pkg::REQ_INSERT, 32'h0, 32'h55, 6'd0);
        send_request(sart_pkg::REQ_FIND, 32'h0, 32'h0, 6'd0);
        send_request(sart_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'h0, 6'h3F);
        send_request(sart_pkg::REQ_INSERT, 32'h0000_0001, 32'hFFFF_FFFF, 6'd0);
        send_request(sart_pkg::REQ_INSERT, 32'h8000_0000, 32'hAAAA_AAAA, 6'd0);
        // equal start lands ahead of the existing one
        send_request(sart_pkg::REQ_INSERT, 32'h8000_0000, 32'h5555_5555, 6'd0);
        send_request(sart_pkg::REQ_FIND, 32'h8000_0000, 32'h0, 6'd0);
        send_request(sart_pkg::REQ_FIND, 32'h7FFF_FFFF, 32'h0, 6'd0);
        // append breaks the order, later searches still use the first-not-below rule
        send_request(sart_pkg::REQ_APPEND, 32'h0000_0010, 32'h1234_5678, 6'd0);
        send_request(sart_pkg::REQ_INSERT, 32'h0000_0020, 32'h8765_4321, 6'd0);
        send_request(sart_pkg::REQ_FIND, 32'h0000_0010, 32'h0, 6'd0);
        send_request(sart_pkg::REQ_REMOVE, 32'h0, 32'h0, 6'h3F);
        send_request(sart_pkg::REQ_REMOVE, 32'h0, 32'h0, sart_pkg::IDX_W'(tbl_count));
        send_request(sart_pkg::REQ_REMOVE, 32'h0, 32'h0, sart_pkg::IDX_W'(tbl_count - 1));
        send_request(sart_pkg::REQ_REMOVE, 32'h0, 32'h0, 6'd1);
        send_request(sart_pkg::REQ_REMOVE, 32'h0, 32'h0, sart_pkg::IDX_W'(tbl_count - 1));
        // key beyond the last entry
        send_request(sart_pkg::REQ_FIND, 32'hFFFF_FFFF, 32'h0, 6'd0);
        send_request(sart_pkg::REQ_REMOVE, 32'h0, 32'h0, 6'd0);
    endtask

    task automatic test_capacity();
        set_capacity(sart_pkg::CAP_W'(0));
        send_request(sart_pkg::REQ_INSERT, 32'h40, 32'h1, 6'd0);
        send_request(sart_pkg::REQ_APPEND, 32'h40, 32'h1, 6'd0);
        send_request(sart_pkg::REQ_FIND, tbl_start[0], 32'h0, 6'd0);
        set_capacity(sart_pkg::CAP_W'(1));
        send_request(sart_pkg::REQ_INSERT, 32'h40, 32'h1, 6'd0);
        send_request(sart_pkg::REQ_FIND, tbl_start[tbl_count - 1], 32'h0, 6'd0);
        send_request(sart_pkg::REQ_REMOVE, 32'h0, 32'h0, 6'd0);
        set_capacity(sart_pkg::CAP_W'(127));
        while (tbl_count < sart_pkg::DEPTH_DEF) begin
            send_request(sart_pkg::REQ_INSERT, $urandom | 32'h1, $urandom,
                         sart_pkg::IDX_W'($urandom_range(0, 63)));
        end
        send_request(sart_pkg::REQ_INSERT, 32'h33, 32'h1, 6'd0);
        send_request(sart_pkg::REQ_APPEND, 32'h33, 32'h1, 6'd0);
        send_request(sart_pkg::REQ_FIND, tbl_start[sart_pkg::DEPTH_DEF - 1], 32'h0, 6'd0);
        send_request(sart_pkg::REQ_FIND, 32'h2, 32'h0, 6'd0);
        send_request(sart_pkg::REQ_REMOVE, 32'h0, 32'h0, 6'd63);
        send_request(sart_pkg::REQ_APPEND, 32'h2, 32'h7, 6'd0);
        set_capacity(sart_pkg::CAP_W'(64));
        send_request(sart_pkg::REQ_INSERT, 32'h3, 32'h1, 6'd0);
    endtask

    task automatic test_random();
        logic [sart_pkg::CAP_W-1:0] caps [8];
        int items [8];
        int p;
        int n;
        caps = '{sart_pkg::CAP_W'(64), sart_pkg::CAP_W'(127), sart_pkg::CAP_W'(3),
                 sart_pkg::CAP_W'(1), sart_pkg::CAP_W'(0), sart_pkg::CAP_W'(48),
                 sart_pkg::CAP_W'(2), sart_pkg::CAP_W'(64)};
        items = '{400, 250, 250, 150, 60, 300, 150, 240};
        for (p = 0; p < 8; p++) begin
            set_capacity(caps[p]);
            for (n = 0; n < items[p]; n++) begin
                random_request();
            end
        end
    endtask

    task automatic test_burst();
        int n;
        wait_drained();
        no_gaps = 1'b1;
        for (n = 0; n < 100; n++) begin
            random_request();
        end
        wait_drained();
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_capacity();
        test_random();
        test_burst();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #(8 * 3000000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
